### design/lbst_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// lbst_pkg
// Shared constants for the look-at basis and side test block.
// ----------------------------------------------------------------------------
package lbst_pkg;

   // position field width (signed fixed point)
   localparam int POS_W = 24;

   // class codes for the front and lateral tests
   localparam int CLS_W = 2;
   typedef logic [CLS_W-1:0] cls_type;
   localparam cls_type CLS_NONE = 2'd0;  // orthogonal / straight ahead
   localparam cls_type CLS_NEG  = 2'd1;  // behind / left
   localparam cls_type CLS_POS  = 2'd2;  // in front / right

endpackage

### design/look_at_basis_and_side_test.sv
`timescale 1ns / 1ps
`default_nettype none
// Pipeline: input transfer to result passes two normalizers in series, each with
//   one root bit and one quotient bit per stage.
// Throughput: one transfer per cycle; the whole pipeline holds while a result
//   waits on rsp_tready.
// Reset: synchronous, active high; clears all stage valid bits.
// ----------------------------------------------------------------------------
// look_at_basis_and_side_test
// Builds the facing, side and up unit axes of a look-at frame and classifies
// a probe point as front/behind and left/right of the observer.
// ----------------------------------------------------------------------------
module look_at_basis_and_side_test #(
   parameter int UNIT_FRAC_BITS = 14
) (
   input  wire logic clock,
   input  wire logic reset,
   // observer_x, observer_y, observer_z, target_x, target_y, target_z,
   // probe_x, probe_y, probe_z (24 bits each, lowest first)
   input  wire logic [9*lbst_pkg::POS_W-1:0] req_tdata,
   input  wire logic req_tvalid,
   output logic      req_tready,
   // side_axis_x/y/z, up_axis_x/y/z, facing_axis_x/y/z (UNIT_FRAC_BITS+2
   // bits each, lowest first), zero fill to whole bytes
   output logic [((9*(UNIT_FRAC_BITS+2)+7)/8)*8-1:0] rsp_tdata,
   // front_class [1:0], lateral_class [3:2], degenerate [4]
   output logic [4:0] rsp_tuser,
   output logic       rsp_tvalid,
   input  wire logic  rsp_tready
);

   localparam int PW   = lbst_pkg::POS_W;
   localparam int DVW  = PW + 1;                 // difference width
   localparam int AW   = UNIT_FRAC_BITS + 2;     // axis component width
   localparam int UVW  = UNIT_FRAC_BITS + 3;     // raw up component width
   localparam int XPW  = 2 * AW;                 // cross product term width
   localparam int DPW  = AW + DVW;               // dot product term width
   localparam int DSW  = DPW + 2;                // dot product sum width
   localparam int TDW  = ((9 * AW + 7) / 8) * 8;
   localparam int FSW  = 1 + 3 * DVW;            // facing unit sideband
   localparam int USW  = 6 * AW + 2 * lbst_pkg::CLS_W + 1;

   // advance every stage together; hold all while a result is not taken
   logic en;
   assign en         = !rsp_tvalid || rsp_tready;
   assign req_tready = en;

   // ---------------------------------------------------------------- stage T0
   // observer-relative target and probe vectors
   logic signed [DVW-1:0] d0_ff [3];
   logic signed [DVW-1:0] p0_ff [3];
   logic                  dg0_ff;
   logic                  v0_ff;
   logic signed [PW-1:0]  obs [3];
   logic signed [PW-1:0]  tgt [3];
   logic signed [PW-1:0]  prb [3];
   logic signed [DVW-1:0] dd  [3];

   always_comb begin
      for (int i = 0; i < 3; i++) begin
         obs[i] = $signed(req_tdata[i*PW +: PW]);
         tgt[i] = $signed(req_tdata[(3+i)*PW +: PW]);
         prb[i] = $signed(req_tdata[(6+i)*PW +: PW]);
         dd[i]  = DVW'(tgt[i]) - DVW'(obs[i]);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         v0_ff <= 1'b0;
      end else if (en) begin
         v0_ff  <= req_tvalid;
         // facing vector with no horizontal part: zero length or along up
         dg0_ff <= (dd[0] == '0) && (dd[2] == '0);
         for (int i = 0; i < 3; i++) begin
            d0_ff[i] <= dd[i];
            p0_ff[i] <= DVW'(prb[i]) - DVW'(obs[i]);
         end
      end
   end

   // ---------------------------------------------------- facing and side units
   logic                  fv;
   logic signed [AW-1:0]  fx, fy, fz;
   logic [FSW-1:0]        fside;
   logic                  sv;
   logic signed [AW-1:0]  sx, sy, sz;
   logic                  sdg;
   logic signed [DVW-1:0] neg_dx;

   assign neg_dx = -d0_ff[0];

   lbst_unitize #(.VW(DVW), .UF(UNIT_FRAC_BITS), .SW(FSW)) u_facing (
      .clock    (clock),
      .reset    (reset),
      .en       (en),
      .in_valid (v0_ff),
      .in_x     (d0_ff[0]),
      .in_y     (d0_ff[1]),
      .in_z     (d0_ff[2]),
      .in_side  ({dg0_ff, p0_ff[2], p0_ff[1], p0_ff[0]}),
      .out_valid(fv),
      .out_x    (fx),
      .out_y    (fy),
      .out_z    (fz),
      .out_side (fside)
   );

   // side axis runs along up x facing = (dz, 0, -dx)
   lbst_unitize #(.VW(DVW), .UF(UNIT_FRAC_BITS), .SW(1)) u_side (
      .clock    (clock),
      .reset    (reset),
      .en       (en),
      .in_valid (v0_ff),
      .in_x     (d0_ff[2]),
      .in_y     ('0),
      .in_z     (neg_dx),
      .in_side  (dg0_ff),
      .out_valid(sv),
      .out_x    (sx),
      .out_y    (sy),
      .out_z    (sz),
      .out_side (sdg)
   );

   // ---------------------------------------------------------------- stage C
   // drop the facing axis for a degenerate item (side is already zero)
   logic signed [AW-1:0]  fc_ff [3];
   logic signed [AW-1:0]  sc_ff [3];
   logic signed [DVW-1:0] pc_ff [3];
   logic                  dgc_ff;
   logic                  vc_ff;
   logic                  fdg;

   assign fdg = fside[FSW-1];

   always_ff @(posedge clock) begin
      if (reset) begin
         vc_ff <= 1'b0;
      end else if (en) begin
         vc_ff    <= fv;
         dgc_ff   <= fdg;
         fc_ff[0] <= fdg ? '0 : fx;
         fc_ff[1] <= fdg ? '0 : fy;
         fc_ff[2] <= fdg ? '0 : fz;
         sc_ff[0] <= sx;
         sc_ff[1] <= sy;
         sc_ff[2] <= sz;
         for (int i = 0; i < 3; i++) pc_ff[i] <= $signed(fside[i*DVW +: DVW]);
      end
   end

   // ---------------------------------------------------------------- stage D
   // products for the up cross product and both probe dot products
   logic signed [XPW-1:0] xa_ff [3];
   logic signed [XPW-1:0] xb_ff [3];
   logic signed [DPW-1:0] fp_ff [3];
   logic signed [DPW-1:0] sp_ff [3];
   logic signed [AW-1:0]  fd_ff [3];
   logic signed [AW-1:0]  sd_ff [3];
   logic                  dgd_ff;
   logic                  vd_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         vd_ff <= 1'b0;
      end else if (en) begin
         vd_ff  <= vc_ff;
         dgd_ff <= dgc_ff;
         for (int i = 0; i < 3; i++) begin
            fd_ff[i] <= fc_ff[i];
            sd_ff[i] <= sc_ff[i];
            fp_ff[i] <= DPW'(fc_ff[i]) * DPW'(pc_ff[i]);
            sp_ff[i] <= DPW'(sc_ff[i]) * DPW'(pc_ff[i]);
            xa_ff[i] <= XPW'(fc_ff[(i+1)%3]) * XPW'(sc_ff[(i+2)%3]);
            xb_ff[i] <= XPW'(fc_ff[(i+2)%3]) * XPW'(sc_ff[(i+1)%3]);
         end
      end
   end

   // ---------------------------------------------------------------- stage E
   // round the cross product back to unit scale; sign tests of the dots
   logic signed [XPW:0]   xdif [3];
   logic [XPW:0]          xmag [3];
   logic [XPW:0]          xrnd [3];
   logic signed [UVW-1:0] ur   [3];
   logic signed [DSW-1:0] dotf, dots;
   lbst_pkg::cls_type     fcls, lcls;

   always_comb begin
      for (int i = 0; i < 3; i++) begin
         xdif[i] = (XPW+1)'(xa_ff[i]) - (XPW+1)'(xb_ff[i]);
         xmag[i] = xdif[i][XPW] ? (XPW+1)'(-xdif[i]) : (XPW+1)'(xdif[i]);
         xrnd[i] = (xmag[i] + ((XPW+1)'(1) << (UNIT_FRAC_BITS - 1))) >> UNIT_FRAC_BITS;
         ur[i]   = xdif[i][XPW] ? -$signed(UVW'(xrnd[i])) : $signed(UVW'(xrnd[i]));
      end
      dotf = DSW'(fp_ff[0]) + DSW'(fp_ff[1]) + DSW'(fp_ff[2]);
      dots = DSW'(sp_ff[0]) + DSW'(sp_ff[1]) + DSW'(sp_ff[2]);
      if (dotf == '0)          fcls = lbst_pkg::CLS_NONE;
      else if (dotf[DSW-1])    fcls = lbst_pkg::CLS_NEG;
      else                     fcls = lbst_pkg::CLS_POS;
      if (dots == '0)          lcls = lbst_pkg::CLS_NONE;
      else if (dots[DSW-1])    lcls = lbst_pkg::CLS_NEG;
      else                     lcls = lbst_pkg::CLS_POS;
   end

   logic signed [UVW-1:0] ue_ff [3];
   logic [USW-1:0]        sbe_ff;
   logic                  ve_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         ve_ff <= 1'b0;
      end else if (en) begin
         ve_ff  <= vd_ff;
         for (int i = 0; i < 3; i++) ue_ff[i] <= ur[i];
         sbe_ff <= {dgd_ff, lcls, fcls, sd_ff[2], sd_ff[1], sd_ff[0],
                    fd_ff[2], fd_ff[1], fd_ff[0]};
      end
   end

   // ------------------------------------------------------------------ up unit
   logic                 uv;
   logic signed [AW-1:0] ux, uy, uz;
   logic [USW-1:0]       usb;

   lbst_unitize #(.VW(UVW), .UF(UNIT_FRAC_BITS), .SW(USW)) u_up (
      .clock    (clock),
      .reset    (reset),
      .en       (en),
      .in_valid (ve_ff),
      .in_x     (ue_ff[0]),
      .in_y     (ue_ff[1]),
      .in_z     (ue_ff[2]),
      .in_side  (sbe_ff),
      .out_valid(uv),
      .out_x    (ux),
      .out_y    (uy),
      .out_z    (uz),
      .out_side (usb)
   );

   // ------------------------------------------------------------------ output
   // the up unit's last stage is the output register
   // side in the lowest bits, then up, then facing
   assign rsp_tvalid = uv;
   assign rsp_tdata  = TDW'({usb[3*AW-1:0], uz, uy, ux, usb[6*AW-1 -: 3*AW]});
   assign rsp_tuser  = usb[USW-1 -: 5];

   // ------------------------------------------------------------- assertions
   a_units_aligned: assert property (@(posedge clock) disable iff (reset)
      (fv == sv) && (fv -> (sdg == fdg)))
      else $error("facing and side units out of step");

   a_degen_axes_zero: assert property (@(posedge clock) disable iff (reset)
      (rsp_tvalid && rsp_tuser[4]) |-> (rsp_tdata == '0))
      else $error("degenerate result with nonzero axes");

   a_degen_classes: assert property (@(posedge clock) disable iff (reset)
      (rsp_tvalid && rsp_tuser[4]) |-> (rsp_tuser[3:0] == '0))
      else $error("degenerate result with nonzero classes");

   a_hold_result: assert property (@(posedge clock) disable iff (reset)
      (rsp_tvalid && !rsp_tready) |=> (rsp_tvalid && $stable(rsp_tdata)))
      else $error("stalled result changed");

endmodule
`default_nettype wire

### design/lbst_unitize.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// lbst_unitize
// Pipelined vector normalizer: sum of squares, one root bit per stage,
// then one quotient bit per stage on three lanes, rounded half away.
// ----------------------------------------------------------------------------
module lbst_unitize #(
   parameter int VW = 25,
   parameter int UF = 14,
   parameter int SW = 1
) (
   input  wire logic                clock,
   input  wire logic                reset,
   input  wire logic                en,
   input  wire logic                in_valid,
   input  wire logic signed [VW-1:0] in_x,
   input  wire logic signed [VW-1:0] in_y,
   input  wire logic signed [VW-1:0] in_z,
   input  wire logic [SW-1:0]       in_side,
   output logic                     out_valid,
   output logic signed [UF+1:0]     out_x,
   output logic signed [UF+1:0]     out_y,
   output logic signed [UF+1:0]     out_z,
   output logic [SW-1:0]            out_side
);

   localparam int RW = VW + 1;       // root width
   localparam int LW = 2 * RW;       // radicand width
   localparam int QW = UF + 2;       // quotient width
   localparam int DW = RW + QW;      // divider remainder width
   localparam int OW = UF + 2;       // output width

   logic signed [VW-1:0] vin [3];
   assign vin[0] = in_x;
   assign vin[1] = in_y;
   assign vin[2] = in_z;

   // stage 1: magnitudes
   logic [VW-1:0]   mag1_ff [3];
   logic [2:0]      sgn1_ff;
   logic [SW-1:0]   sd1_ff;
   logic            v1_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         v1_ff <= 1'b0;
      end else if (en) begin
         v1_ff  <= in_valid;
         sd1_ff <= in_side;
         for (int i = 0; i < 3; i++) begin
            sgn1_ff[i] <= vin[i][VW-1];
            mag1_ff[i] <= vin[i][VW-1] ? VW'(-vin[i]) : VW'(vin[i]);
         end
      end
   end

   // stage 2: squares
   logic [2*VW-1:0] sq2_ff  [3];
   logic [VW-1:0]   mag2_ff [3];
   logic [2:0]      sgn2_ff;
   logic [SW-1:0]   sd2_ff;
   logic            v2_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         v2_ff <= 1'b0;
      end else if (en) begin
         v2_ff   <= v1_ff;
         sd2_ff  <= sd1_ff;
         sgn2_ff <= sgn1_ff;
         for (int i = 0; i < 3; i++) begin
            mag2_ff[i] <= mag1_ff[i];
            sq2_ff[i]  <= mag1_ff[i] * mag1_ff[i];
         end
      end
   end

   // square root: stage 0 sums, stages 1..RW each settle one root bit
   logic [RW+1:0]   rem_ff  [RW+1];
   logic [RW-1:0]   root_ff [RW+1];
   logic [LW-1:0]   x_ff    [RW+1];
   logic [VW-1:0]   magq_ff [RW+1][3];
   logic [2:0]      sgnq_ff [RW+1];
   logic [SW-1:0]   sdq_ff  [RW+1];
   logic            vq_ff   [RW+1];

   always_ff @(posedge clock) begin
      if (reset) begin
         vq_ff[0] <= 1'b0;
      end else if (en) begin
         vq_ff[0]   <= v2_ff;
         sdq_ff[0]  <= sd2_ff;
         sgnq_ff[0] <= sgn2_ff;
         rem_ff[0]  <= '0;
         root_ff[0] <= '0;
         x_ff[0]    <= LW'(sq2_ff[0]) + LW'(sq2_ff[1]) + LW'(sq2_ff[2]);
         for (int i = 0; i < 3; i++) magq_ff[0][i] <= mag2_ff[i];
      end
   end

   for (genvar j = 1; j <= RW; j++) begin : g_sqrt
      logic [RW+2:0] rsh;
      logic [RW+2:0] trl;
      assign rsh = {rem_ff[j-1][RW:0], x_ff[j-1][LW-1 -: 2]};
      assign trl = {1'b0, root_ff[j-1], 2'b01};

      always_ff @(posedge clock) begin
         if (reset) begin
            vq_ff[j] <= 1'b0;
         end else if (en) begin
            vq_ff[j]   <= vq_ff[j-1];
            sdq_ff[j]  <= sdq_ff[j-1];
            sgnq_ff[j] <= sgnq_ff[j-1];
            x_ff[j]    <= x_ff[j-1] << 2;
            for (int i = 0; i < 3; i++) magq_ff[j][i] <= magq_ff[j-1][i];
            if (rsh >= trl) begin
               rem_ff[j]  <= (RW+2)'(rsh - trl);
               root_ff[j] <= {root_ff[j-1][RW-2:0], 1'b1};
            end else begin
               rem_ff[j]  <= rsh[RW+1:0];
               root_ff[j] <= {root_ff[j-1][RW-2:0], 1'b0};
            end
         end
      end
   end

   // divider: stage 0 forms the rounded numerators, stages 1..QW one bit each
   logic [DW-1:0]   drem_ff [QW+1][3];
   logic [QW-1:0]   dq_ff   [QW+1][3];
   logic [RW-1:0]   dn_ff   [QW+1];
   logic [2:0]      dsg_ff  [QW+1];
   logic [SW-1:0]   dsd_ff  [QW+1];
   logic            dv_ff   [QW+1];

   always_ff @(posedge clock) begin
      if (reset) begin
         dv_ff[0] <= 1'b0;
      end else if (en) begin
         dv_ff[0]  <= vq_ff[RW];
         dsd_ff[0] <= sdq_ff[RW];
         dsg_ff[0] <= sgnq_ff[RW];
         dn_ff[0]  <= root_ff[RW];
         for (int i = 0; i < 3; i++) begin
            dq_ff[0][i]   <= '0;
            drem_ff[0][i] <= (DW'(magq_ff[RW][i]) << UF) + DW'(root_ff[RW] >> 1);
         end
      end
   end

   for (genvar k = 1; k <= QW; k++) begin : g_div
      localparam int SH = QW - k;
      logic [DW-1:0] dsub;
      assign dsub = DW'(dn_ff[k-1]) << SH;

      always_ff @(posedge clock) begin
         if (reset) begin
            dv_ff[k] <= 1'b0;
         end else if (en) begin
            dv_ff[k]  <= dv_ff[k-1];
            dsd_ff[k] <= dsd_ff[k-1];
            dsg_ff[k] <= dsg_ff[k-1];
            dn_ff[k]  <= dn_ff[k-1];
            for (int i = 0; i < 3; i++) begin
               if (drem_ff[k-1][i] >= dsub) begin
                  drem_ff[k][i] <= drem_ff[k-1][i] - dsub;
                  dq_ff[k][i]   <= dq_ff[k-1][i] | (QW'(1) << SH);
               end else begin
                  drem_ff[k][i] <= drem_ff[k-1][i];
                  dq_ff[k][i]   <= dq_ff[k-1][i];
               end
            end
         end
      end
   end

   // output stage: saturate, restore sign, zero for a zero-length vector
   localparam logic [QW-1:0] ONE = QW'(1) << UF;

   logic signed [OW-1:0] o_ff [3];
   logic [SW-1:0]        osd_ff;
   logic                 ov_ff;
   logic [QW-1:0]        qs [3];

   always_comb begin
      for (int i = 0; i < 3; i++) begin
         qs[i] = (dq_ff[QW][i] > ONE) ? ONE : dq_ff[QW][i];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         ov_ff <= 1'b0;
      end else if (en) begin
         ov_ff  <= dv_ff[QW];
         osd_ff <= dsd_ff[QW];
         for (int i = 0; i < 3; i++) begin
            if (dn_ff[QW] == '0) begin
               o_ff[i] <= '0;
            end else if (dsg_ff[QW][i]) begin
               o_ff[i] <= -$signed(OW'(qs[i]));
            end else begin
               o_ff[i] <= $signed(OW'(qs[i]));
            end
         end
      end
   end

   assign out_valid = ov_ff;
   assign out_x     = o_ff[0];
   assign out_y     = o_ff[1];
   assign out_z     = o_ff[2];
   assign out_side  = osd_ff;

endmodule
`default_nettype wire
